// ----- src/sutag_pkg.sv -----
// Shared types and command codes for the sorted union block.
`default_nettype none
package sutag_pkg;

    localparam int KEY_W = 31;
    localparam int PAY_W = 16;

    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_FETCH       = 2'd2;
    localparam logic [1:0] CMD_CLEAR       = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } rec_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
        logic             in_second;
        logic             in_first;
    } uent_t;

endpackage
`default_nettype wire

// ----- src/sutag_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sutag_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/sutag_sort.sv -----
// Stable in-place insertion sort of one record list held in a RAM.
`default_nettype none
module sutag_sort
    import sutag_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [$clog2(DEPTH+1)-1:0] n,
    input  wire rec_t                       rdata,
    output logic      [$clog2(DEPTH)-1:0]   raddr,
    output logic                            we,
    output logic      [$clog2(DEPTH)-1:0]   waddr,
    output rec_t                            wdata,
    output logic                            busy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OUT   = 3'd1;
    localparam logic [2:0] S_TLD   = 3'd2;
    localparam logic [2:0] S_INNER = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    rec_t          t_reg, t_next;
    logic [CW-1:0] im1;
    logic [CW-1:0] jm2;

    assign im1  = i_reg - ONE_C;
    assign jm2  = j_reg - TWO_C;
    assign busy = (state_reg != S_IDLE);

    // Shift larger records up one slot until the held record fits
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        raddr      = i_reg[AW-1:0];
        we         = 1'b0;
        waddr      = j_reg[AW-1:0];
        wdata      = t_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next     = ONE_C;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                raddr = i_reg[AW-1:0];
                if (i_reg >= n)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_TLD;
                end
            end
            S_TLD:
            begin
                raddr      = im1[AW-1:0];
                t_next     = rdata;
                j_next     = i_reg;
                state_next = S_INNER;
            end
            S_INNER:
            begin
                raddr = jm2[AW-1:0];
                we    = 1'b1;
                if (rdata.key > t_reg.key)
                begin
                    wdata  = rdata;
                    j_next = j_reg - ONE_C;
                    if (j_reg == ONE_C)
                    begin
                        state_next = S_PUT;
                    end
                end
                else
                begin
                    i_next     = i_reg + ONE_C;
                    state_next = S_OUT;
                end
            end
            S_PUT:
            begin
                we         = 1'b1;
                i_next     = i_reg + ONE_C;
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

`ifndef ASSERT_OFF
    a_j_le_i: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INNER) |-> (j_reg <= i_reg && j_reg != '0))
        else $error("sort insertion index out of range");
    a_i_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TLD) |-> (i_reg < n))
        else $error("sort outer index past list end");
    a_put_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (j_reg == '0))
        else $error("sort put slot not at head");
`endif

endmodule
`default_nettype wire

// ----- src/sutag_merge.sv -----
// Dedup count pass and tagged merge of two sorted lists into the union RAM.
`default_nettype none
module sutag_merge
    import sutag_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int LIMIT = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [$clog2(DEPTH+1)-1:0] n1,
    input  wire logic [$clog2(DEPTH+1)-1:0] n2,
    input  wire rec_t                       a_rdata,
    input  wire rec_t                       b_rdata,
    output logic      [$clog2(DEPTH)-1:0]   a_raddr,
    output logic      [$clog2(DEPTH)-1:0]   b_raddr,
    output logic                            u_we,
    output logic      [$clog2(LIMIT)-1:0]   u_waddr,
    output uent_t                           u_wdata,
    output logic      [$clog2(LIMIT+1)-1:0] ucount,
    output logic                            ovf_set,
    output logic                            busy
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int UAW = $clog2(LIMIT);
    localparam int UW  = $clog2(LIMIT + 1);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [UW-1:0] UONE_C = UW'(1);
    localparam logic [UW-1:0] LIM_C  = UW'(LIMIT);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_CRD  = 3'd1;
    localparam logic [2:0] M_CCMP = 3'd2;
    localparam logic [2:0] M_RD   = 3'd3;
    localparam logic [2:0] M_CMP  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [UW-1:0]    ia_reg, ia_next;
    logic [UW-1:0]    keep_reg, keep_next;
    logic [UW-1:0]    room_reg, room_next;
    logic [UW-1:0]    uc_reg, uc_next;
    logic             pa_v_reg, pa_v_next;
    logic             pb_v_reg, pb_v_next;
    logic [KEY_W-1:0] pa_reg, pa_next;
    logic [KEY_W-1:0] pb_reg, pb_next;
    logic             av, bv, dup_a, dup_b, take_a, take_b;

    assign a_raddr = i_reg[AW-1:0];
    assign b_raddr = j_reg[AW-1:0];
    assign u_waddr = uc_reg[UAW-1:0];
    assign ucount  = uc_reg;
    assign busy    = (state_reg != M_IDLE);

    assign av     = (i_reg < n1);
    assign bv     = (j_reg < n2);
    assign dup_a  = av && pa_v_reg && (a_rdata.key == pa_reg);
    assign dup_b  = bv && pb_v_reg && (b_rdata.key == pb_reg);
    assign take_a = !bv || (av && (a_rdata.key < b_rdata.key));
    assign take_b = !av || (b_rdata.key < a_rdata.key);

    // Count distinct first-list keys, then walk both lists in key order
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        ia_next    = ia_reg;
        keep_next  = keep_reg;
        room_next  = room_reg;
        uc_next    = uc_reg;
        pa_v_next  = pa_v_reg;
        pb_v_next  = pb_v_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        u_we       = 1'b0;
        u_wdata    = '{key: a_rdata.key, payload: a_rdata.payload,
                       in_second: 1'b0, in_first: 1'b1};
        ovf_set    = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    cnt_next   = '0;
                    pa_v_next  = 1'b0;
                    state_next = M_CRD;
                end
            end
            M_CRD:
            begin
                if (i_reg >= n1)
                begin
                    if (32'(cnt_reg) > LIMIT)
                    begin
                        keep_next = LIM_C;
                        ovf_set   = 1'b1;
                    end
                    else
                    begin
                        keep_next = UW'(cnt_reg);
                    end
                    room_next  = LIM_C - keep_next;
                    i_next     = '0;
                    j_next     = '0;
                    ia_next    = '0;
                    uc_next    = '0;
                    pa_v_next  = 1'b0;
                    pb_v_next  = 1'b0;
                    state_next = M_RD;
                end
                else
                begin
                    state_next = M_CCMP;
                end
            end
            M_CCMP:
            begin
                if (!pa_v_reg || (a_rdata.key != pa_reg))
                begin
                    cnt_next = cnt_reg + ONE_C;
                end
                pa_v_next  = 1'b1;
                pa_next    = a_rdata.key;
                i_next     = i_reg + ONE_C;
                state_next = M_CRD;
            end
            M_RD:
            begin
                state_next = M_CMP;
            end
            M_CMP:
            begin
                state_next = M_RD;
                if (!av && !bv)
                begin
                    state_next = M_IDLE;
                end
                else if (dup_a)
                begin
                    i_next = i_reg + ONE_C;
                end
                else if (dup_b)
                begin
                    j_next = j_reg + ONE_C;
                end
                else if (take_a)
                begin
                    if (ia_reg < keep_reg)
                    begin
                        u_we    = 1'b1;
                        uc_next = uc_reg + UONE_C;
                    end
                    ia_next   = ia_reg + UONE_C;
                    pa_v_next = 1'b1;
                    pa_next   = a_rdata.key;
                    i_next    = i_reg + ONE_C;
                end
                else if (take_b)
                begin
                    u_wdata = '{key: b_rdata.key, payload: b_rdata.payload,
                                in_second: 1'b1, in_first: 1'b0};
                    if (room_reg != '0)
                    begin
                        u_we      = 1'b1;
                        uc_next   = uc_reg + UONE_C;
                        room_next = room_reg - UONE_C;
                    end
                    else
                    begin
                        ovf_set = 1'b1;
                    end
                    pb_v_next = 1'b1;
                    pb_next   = b_rdata.key;
                    j_next    = j_reg + ONE_C;
                end
                else
                begin
                    u_wdata.in_second = 1'b1;
                    if (ia_reg < keep_reg)
                    begin
                        u_we    = 1'b1;
                        uc_next = uc_reg + UONE_C;
                    end
                    ia_next   = ia_reg + UONE_C;
                    pa_v_next = 1'b1;
                    pb_v_next = 1'b1;
                    pa_next   = a_rdata.key;
                    pb_next   = b_rdata.key;
                    i_next    = i_reg + ONE_C;
                    j_next    = j_reg + ONE_C;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
            ia_reg    <= '0;
            keep_reg  <= '0;
            room_reg  <= '0;
            uc_reg    <= '0;
            pa_v_reg  <= 1'b0;
            pb_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
            ia_reg    <= ia_next;
            keep_reg  <= keep_next;
            room_reg  <= room_next;
            uc_reg    <= uc_next;
            pa_v_reg  <= pa_v_next;
            pb_v_reg  <= pb_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= pa_next;
        pb_reg <= pb_next;
    end

`ifndef ASSERT_OFF
    a_uc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(uc_reg) <= LIMIT)
        else $error("union count past limit");
    a_keep_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_CMP) |-> (32'(keep_reg) + 32'(room_reg) <= LIMIT))
        else $error("merge quota out of balance");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        u_we |-> (32'(uc_reg) < LIMIT))
        else $error("union write with no room");
`endif

endmodule
`default_nettype wire

// ----- src/sorted_union_with_membership_tags.sv -----
// Top level of the sorted union block: command decode, list loads and fetch path.
//
// Usage: drive cmd, key and payload with start high; the command transfers at
// a rising edge where start is high and busy is low. Loads (first or second
// list) and clear return nothing and leave busy low. A load with key zero is
// dropped; a load into a full list is dropped and sets the truncated flag.
// A fetch returns exactly one result, marked by done high for one cycle, on
// valid_res, key_res, payload_res, in_first, in_second, last and truncated.
// On a built union, done rises after T_FETCH and T_FRD, the registered read
// of the union RAM (T_FRD is skipped when the union is exhausted); the
// next command can transfer at the edge that ends the done cycle.
// The first fetch after any load or clear first sorts both lists in place,
// each in its own RAM by insertion sort, then merges them into the union RAM;
// busy stays high for the whole build.
// The receiver cannot hold results off: done is a one-cycle strobe.
// Reset empties both lists, the union and the overflow flag behind truncated;
// the RAMs need no clearing because only entries below the counts are read.
`default_nettype none
module sorted_union_with_membership_tags
    import sutag_pkg::*;
#(
    parameter int LIST_DEPTH  = 1024,
    parameter int MERGE_LIMIT = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       cmd,
    input  wire logic [KEY_W-1:0] key,
    input  wire logic [PAY_W-1:0] payload,
    output logic                  done,
    output logic                  valid_res,
    output logic      [KEY_W-1:0] key_res,
    output logic      [PAY_W-1:0] payload_res,
    output logic                  in_first,
    output logic                  in_second,
    output logic                  last,
    output logic                  truncated
);

    localparam int AW  = $clog2(LIST_DEPTH);
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int UAW = $clog2(MERGE_LIMIT);
    localparam int UW  = $clog2(MERGE_LIMIT + 1);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [CW-1:0] FULL_C = CW'(LIST_DEPTH);
    localparam logic [UW-1:0] UONE_C = UW'(1);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_SORT  = 3'd1;
    localparam logic [2:0] T_MERGE = 3'd2;
    localparam logic [2:0] T_FETCH = 3'd3;
    localparam logic [2:0] T_FRD   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt1_reg, cnt1_next;
    logic [CW-1:0] cnt2_reg, cnt2_next;
    logic [UW-1:0] fp_reg, fp_next;
    logic          ready_reg, ready_next;
    logic          ovf_reg, ovf_next;
    logic          done_reg, done_next;
    uent_t         res_reg, res_next;
    logic          vres_reg, vres_next;
    logic          last_reg, last_next;
    logic          trunc_reg, trunc_next;

    logic          accept;
    logic          sort_start, merge_start;
    logic          load_we1, load_we2;

    // List RAM ports
    logic          a_we, b_we;
    logic [AW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
    rec_t          a_wdata, b_wdata, a_rdata, b_rdata;

    // Sorter ports
    logic          sa_we, sb_we, sa_busy, sb_busy;
    logic [AW-1:0] sa_waddr, sb_waddr, sa_raddr, sb_raddr;
    rec_t          sa_wdata, sb_wdata;

    // Merge ports
    logic           m_we, m_ovf, m_busy;
    logic [AW-1:0]  ma_raddr, mb_raddr;
    logic [UAW-1:0] m_waddr;
    uent_t          m_wdata, u_rdata;
    logic [UW-1:0]  ucount;

    assign accept = start && (state_reg == T_IDLE);
    assign busy   = (state_reg != T_IDLE);

    // Route list RAM ports between loads, sorters and merge
    assign load_we1 = accept && (cmd == CMD_LOAD_FIRST) && (key != '0) && (cnt1_reg != FULL_C);
    assign load_we2 = accept && (cmd == CMD_LOAD_SECOND) && (key != '0) && (cnt2_reg != FULL_C);
    assign a_we    = load_we1 || sa_we;
    assign b_we    = load_we2 || sb_we;
    assign a_waddr = load_we1 ? cnt1_reg[AW-1:0] : sa_waddr;
    assign b_waddr = load_we2 ? cnt2_reg[AW-1:0] : sb_waddr;
    assign a_wdata = load_we1 ? rec_t'{key: key, payload: payload} : sa_wdata;
    assign b_wdata = load_we2 ? rec_t'{key: key, payload: payload} : sb_wdata;
    assign a_raddr = (state_reg == T_SORT) ? sa_raddr : ma_raddr;
    assign b_raddr = (state_reg == T_SORT) ? sb_raddr : mb_raddr;

    sutag_ram #(.WIDTH($bits(rec_t)), .DEPTH(LIST_DEPTH)) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sutag_ram #(.WIDTH($bits(rec_t)), .DEPTH(LIST_DEPTH)) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    sutag_ram #(.WIDTH($bits(uent_t)), .DEPTH(MERGE_LIMIT)) u_union_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (fp_reg[UAW-1:0]),
        .rdata (u_rdata)
    );

    sutag_sort #(.DEPTH(LIST_DEPTH)) u_sort_first (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .n     (cnt1_reg),
        .rdata (a_rdata),
        .raddr (sa_raddr),
        .we    (sa_we),
        .waddr (sa_waddr),
        .wdata (sa_wdata),
        .busy  (sa_busy)
    );

    sutag_sort #(.DEPTH(LIST_DEPTH)) u_sort_second (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .n     (cnt2_reg),
        .rdata (b_rdata),
        .raddr (sb_raddr),
        .we    (sb_we),
        .waddr (sb_waddr),
        .wdata (sb_wdata),
        .busy  (sb_busy)
    );

    sutag_merge #(.DEPTH(LIST_DEPTH), .LIMIT(MERGE_LIMIT)) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (merge_start),
        .n1      (cnt1_reg),
        .n2      (cnt2_reg),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .a_raddr (ma_raddr),
        .b_raddr (mb_raddr),
        .u_we    (m_we),
        .u_waddr (m_waddr),
        .u_wdata (m_wdata),
        .ucount  (ucount),
        .ovf_set (m_ovf),
        .busy    (m_busy)
    );

    // Decode commands, sequence the build and drive the fetch result
    always_comb
    begin
        state_next  = state_reg;
        cnt1_next   = cnt1_reg;
        cnt2_next   = cnt2_reg;
        fp_next     = fp_reg;
        ready_next  = ready_reg;
        ovf_next    = ovf_reg || m_ovf;
        done_next   = 1'b0;
        res_next    = res_reg;
        vres_next   = vres_reg;
        last_next   = last_reg;
        trunc_next  = trunc_reg;
        sort_start  = 1'b0;
        merge_start = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_LOAD_FIRST, CMD_LOAD_SECOND:
                        begin
                            ready_next = 1'b0;
                            fp_next    = '0;
                            if (key != '0)
                            begin
                                if (cmd == CMD_LOAD_FIRST)
                                begin
                                    if (cnt1_reg == FULL_C)
                                        ovf_next = 1'b1;
                                    else
                                        cnt1_next = cnt1_reg + ONE_C;
                                end
                                else
                                begin
                                    if (cnt2_reg == FULL_C)
                                        ovf_next = 1'b1;
                                    else
                                        cnt2_next = cnt2_reg + ONE_C;
                                end
                            end
                        end
                        CMD_FETCH:
                        begin
                            if (ready_reg)
                            begin
                                state_next = T_FETCH;
                            end
                            else
                            begin
                                sort_start = 1'b1;
                                state_next = T_SORT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt1_next  = '0;
                            cnt2_next  = '0;
                            fp_next    = '0;
                            ready_next = 1'b0;
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                            state_next = T_IDLE;
                        end
                    endcase
                end
            end
            T_SORT:
            begin
                if (!sa_busy && !sb_busy)
                begin
                    merge_start = 1'b1;
                    state_next  = T_MERGE;
                end
            end
            T_MERGE:
            begin
                if (!m_busy)
                begin
                    ready_next = 1'b1;
                    fp_next    = '0;
                    state_next = T_FETCH;
                end
            end
            T_FETCH:
            begin
                if (fp_reg < ucount)
                begin
                    state_next = T_FRD;
                end
                else
                begin
                    done_next  = 1'b1;
                    vres_next  = 1'b0;
                    res_next   = '0;
                    last_next  = 1'b0;
                    trunc_next = ovf_reg;
                    state_next = T_IDLE;
                end
            end
            T_FRD:
            begin
                done_next  = 1'b1;
                vres_next  = 1'b1;
                res_next   = u_rdata;
                last_next  = ((fp_reg + UONE_C) == ucount);
                trunc_next = ovf_reg;
                fp_next    = fp_reg + UONE_C;
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Hold control state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
            fp_reg    <= '0;
            ready_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt1_reg  <= cnt1_next;
            cnt2_reg  <= cnt2_next;
            fp_reg    <= fp_next;
            ready_reg <= ready_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        vres_reg  <= vres_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    assign done        = done_reg;
    assign valid_res   = vres_reg;
    assign key_res     = res_reg.key;
    assign payload_res = res_reg.payload;
    assign in_first    = res_reg.in_first;
    assign in_second   = res_reg.in_second;
    assign last        = last_reg;
    assign truncated   = trunc_reg;

`ifndef ASSERT_OFF
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held two cycles");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !vres_reg) |-> (res_reg == '0 && !last_reg))
        else $error("exhausted result carries data");
    a_fp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (fp_reg <= ucount))
        else $error("fetch pointer past union count");
    a_valid_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && vres_reg) |-> (res_reg.in_first || res_reg.in_second))
        else $error("union entry without membership tag");
`endif

endmodule
`default_nettype wire
